// ===== src/aesk_pkg.sv =====
// Package for the AES-128 key schedule: types, S-box, round constants, round function.
`timescale 1ns / 1ps
`default_nettype none
package aesk_pkg;

  typedef logic [127:0] key_t;
  typedef logic [31:0]  word_t;
  typedef logic [7:0]   byte_t;

  // Round keys per cipher key, original key included
  localparam int ROUND_KEYS = 11;
  localparam int LAST_ROUND = ROUND_KEYS - 1;
  localparam int IDX_W      = 4;

  // Round constants, entry r-1 feeds round r
  localparam byte_t RCON [0:LAST_ROUND-1] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  // Forward S-box
  localparam byte_t SBOX [0:255] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // RotWord then SubWord, round constant into the top byte
  function automatic word_t sub_rot_word(input word_t w, input byte_t rc);
    word_t r;
    r = {w[23:0], w[31:24]};
    return {SBOX[r[31:24]] ^ rc, SBOX[r[23:16]], SBOX[r[15:8]], SBOX[r[7:0]]};
  endfunction

  // Next round key from the previous one
  function automatic key_t next_round_key(input key_t k, input byte_t rc);
    word_t n0;
    word_t n1;
    word_t n2;
    word_t n3;
    n0 = k[127:96] ^ sub_rot_word(k[31:0], rc);
    n1 = k[95:64] ^ n0;
    n2 = k[63:32] ^ n1;
    n3 = k[31:0] ^ n2;
    return {n0, n1, n2, n3};
  endfunction

endpackage
`default_nettype wire

// ===== src/aesk_round_cell.sv =====
// One cell of the key chain: derives and holds one round key from its upstream neighbor.
`timescale 1ns / 1ps
`default_nettype none
module aesk_round_cell import aesk_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  adv,
  input  wire logic  up_valid,
  input  wire key_t  up_key,
  input  wire byte_t rcon,
  output logic       valid,
  output key_t       key
);

  logic valid_r;
  logic valid_nxt;
  key_t key_r;

  // occupancy moves with the chain
  always_comb begin
    valid_nxt = adv ? up_valid : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload: one round of expansion on the way in
  always_ff @(posedge clk) begin
    if (adv && up_valid) begin
      key_r <= next_round_key(up_key, rcon);
    end
  end

  assign valid = valid_r;
  assign key   = key_r;

endmodule
`default_nettype wire

// ===== src/aes128_key_expansion_top.sv =====
// Top level of the AES-128 key schedule generator: input cell, round-cell chain, output stage.
//
//  channel | ports                                         | beat
//  --------+-----------------------------------------------+---------------------------
//  in      | in_valid, in_stall, in_key_high, in_key_low   | one 128-bit cipher key
//  out     | out_valid, out_stall, out_round_index,        | one round key, 11 per key
//          | out_round_key_high/low, out_last_key          |
//
// A key enters cell 0 and moves one cell per cycle, while out_stall does not hold it, down a
// chain of ten round cells; each move hands the current round key to the output register, so a
// key gives 11 output beats in order. The next key enters in the cycle the previous one leaves
// the last cell. Reset (rst_n low, synchronous) empties the chain and the output register.
// out_stall freezes the whole chain while out_valid is high; in_stall is high while a key is
// in flight, but drops while the key leaves the last cell.
`timescale 1ns / 1ps
`default_nettype none
module aes128_key_expansion_top import aesk_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [63:0]        in_key_high,
  input  wire logic [63:0]        in_key_low,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [IDX_W-1:0]        out_round_index,
  output logic [63:0]             out_round_key_high,
  output logic [63:0]             out_round_key_low,
  output logic                    out_last_key
);

  logic            cell_valid [0:LAST_ROUND];
  key_t            cell_key   [0:LAST_ROUND];
  logic            any_valid;
  logic            adv;
  logic            in_acc;
  logic            v0_r;
  logic            v0_nxt;
  key_t            k0_r;
  logic [IDX_W-1:0] sel_idx;
  key_t            sel_key;
  logic            out_valid_r;
  logic            out_valid_nxt;
  logic [IDX_W-1:0] out_idx_r;
  key_t            out_key_r;
  logic            out_last_r;

  // chain occupancy and advance
  always_comb begin
    any_valid = 1'b0;
    for (int k = 0; k <= LAST_ROUND; k++) begin
      any_valid = any_valid | cell_valid[k];
    end
  end

  assign adv      = any_valid && (!out_valid_r || !out_stall);
  assign in_stall = any_valid && !(cell_valid[LAST_ROUND] && adv);
  assign in_acc   = in_valid && !in_stall;

  // cell 0: the original key
  assign v0_nxt = in_acc || (v0_r && !adv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= v0_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      k0_r <= {in_key_high, in_key_low};
    end
  end

  assign cell_valid[0] = v0_r;
  assign cell_key[0]   = k0_r;

  // round cells 1..10
  for (genvar gi = 1; gi <= LAST_ROUND; gi++) begin : g_cell
    aesk_round_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .up_valid (cell_valid[gi-1]),
      .up_key   (cell_key[gi-1]),
      .rcon     (RCON[gi-1]),
      .valid    (cell_valid[gi]),
      .key      (cell_key[gi])
    );
  end

  // pick the occupied cell (at most one)
  always_comb begin
    sel_idx = '0;
    sel_key = '0;
    for (int k = 0; k <= LAST_ROUND; k++) begin
      if (cell_valid[k]) begin
        sel_idx = IDX_W'(k);
      end
      sel_key = sel_key | (cell_valid[k] ? cell_key[k] : '0);
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = adv || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_idx_r  <= sel_idx;
      out_key_r  <= sel_key;
      out_last_r <= cell_valid[LAST_ROUND];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_round_index    = out_idx_r;
  assign out_round_key_high = out_key_r[127:64];
  assign out_round_key_low  = out_key_r[63:0];
  assign out_last_key       = out_last_r;

endmodule
`default_nettype wire

// ===== bench/tb_aes128_key_expansion_top.sv =====
// Testbench for the AES-128 key schedule generator: directed and random keys in, eleven round keys checked out.
`timescale 1ns / 1ps
module tb_aes128_key_expansion_top;
  import aesk_pkg::*;

  typedef struct {
    logic [IDX_W-1:0] idx;
    logic [63:0]      key_hi;
    logic [63:0]      key_lo;
    logic             is_last;
  } round_key_t;

  // Random keys sent after the directed ones
  localparam int RANDOM_KEYS = 206;
  localparam int CALM_TAIL   = 30;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] in_key_high = '0;
  logic [63:0] in_key_low = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [IDX_W-1:0] out_round_index;
  logic [63:0] out_round_key_high;
  logic [63:0] out_round_key_low;
  logic        out_last_key;

  byte_t       sub_tab [0:255];
  logic [127:0] cipher_keys[$];
  round_key_t  round_keys_due[$];
  int          keys_total = 0;
  int          keys_sent = 0;
  int          errors = 0;
  int          key_gap = 0;
  int          stall_left = 0;
  logic        calm;

  aes128_key_expansion_top uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_key_high        (in_key_high),
    .in_key_low         (in_key_low),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_round_index    (out_round_index),
    .out_round_key_high (out_round_key_high),
    .out_round_key_low  (out_round_key_low),
    .out_last_key       (out_last_key)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // No new random gaps or stalls are started on either side near the end of the run
  assign calm = (keys_sent + CALM_TAIL >= keys_total);

  // GF(2^8) multiply, AES polynomial
  function automatic byte_t gf_mul(input byte_t a, input byte_t b);
    byte_t p;
    byte_t x;
    int k;
    p = '0;
    x = a;
    for (k = 0; k < 8; k++) begin
      if (b[k]) p ^= x;
      x = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    end
    return p;
  endfunction

  // Expand one cipher key and queue its eleven round keys
  function automatic void expand_cipher_key(input logic [63:0] hi, input logic [63:0] lo);
    word_t w [0:43];
    word_t t;
    byte_t rc;
    round_key_t rk;
    int i;
    int r;
    w[0] = hi[63:32];
    w[1] = hi[31:0];
    w[2] = lo[63:32];
    w[3] = lo[31:0];
    rc = 8'h01;
    for (i = 4; i < 44; i++) begin
      if (i % 4 == 0) begin
        t = {w[i-1][23:0], w[i-1][31:24]};
        t = {sub_tab[t[31:24]] ^ rc, sub_tab[t[23:16]], sub_tab[t[15:8]], sub_tab[t[7:0]]};
        rc = gf_mul(rc, 8'h02);
        w[i] = w[i-4] ^ t;
      end else begin
        w[i] = w[i-4] ^ w[i-1];
      end
    end
    for (r = 0; r < ROUND_KEYS; r++) begin
      rk.idx     = r[IDX_W-1:0];
      rk.key_hi  = {w[4*r], w[4*r+1]};
      rk.key_lo  = {w[4*r+2], w[4*r+3]};
      rk.is_last = (r == ROUND_KEYS - 1);
      round_keys_due.push_back(rk);
    end
  endfunction

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
    end
  endtask

  // Forward S-box: multiplicative inverse then affine map
  initial begin : sbox_build
    byte_t inv;
    byte_t b;
    int v;
    int c;
    for (v = 0; v < 256; v++) begin
      inv = '0;
      if (v != 0) begin
        for (c = 1; c < 256; c++) begin
          if (gf_mul(v[7:0], c[7:0]) == 8'h01) inv = c[7:0];
        end
      end
      b = inv;
      sub_tab[v] = b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]}
                   ^ {b[3:0], b[7:4]} ^ 8'h63;
    end
  end

  // Input driver: one key per beat, payload held while stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expand_cipher_key(in_key_high, in_key_low);
        keys_sent++;
      end
      if (in_valid && in_stall) begin
        // hold the beat
      end else if (key_gap > 0) begin
        key_gap--;
        in_valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        key_gap = $urandom_range(0, 12);
        in_valid <= 1'b0;
      end else if (cipher_keys.size() > 0) begin
        {in_key_high, in_key_low} <= cipher_keys.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output monitor and stall generator
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (round_keys_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected round key, expected none, actual %h %h %h %b", $time,
                   out_round_index, out_round_key_high, out_round_key_low, out_last_key);
        end else begin
          round_key_t rk;
          rk = round_keys_due.pop_front();
          check_field("round_index", 64'(rk.idx), 64'(out_round_index));
          check_field("round_key_high", rk.key_hi, out_round_key_high);
          check_field("round_key_low", rk.key_lo, out_round_key_low);
          check_field("last_key", 64'(rk.is_last), 64'(out_last_key));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 12);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin : stimulus
    logic [127:0] k;
    byte_t bt;
    int n;
    // directed keys: extremes, known vector, S-box and rotation edges
    cipher_keys.push_back('0);
    cipher_keys.push_back({128{1'b1}});
    cipher_keys.push_back(128'h2b7e151628aed2a6abf7158809cf4f3c);
    cipher_keys.push_back(128'h000102030405060708090a0b0c0d0e0f);
    cipher_keys.push_back({16{8'haa}});
    cipher_keys.push_back({16{8'h55}});
    cipher_keys.push_back({{64{1'b1}}, 64'h0});
    cipher_keys.push_back({64'h0, {64{1'b1}}});
    cipher_keys.push_back({1'b1, 127'h0});
    cipher_keys.push_back(128'h1);
    cipher_keys.push_back({96'h0, 32'hff000000});
    cipher_keys.push_back({96'h0, 32'h000000ff});
    cipher_keys.push_back({96'h0, 32'h52525252});
    cipher_keys.push_back(128'h0f0e0d0c0b0a09080706050403020100);
    // random keys, some with repeated bytes or a single set bit
    for (n = 0; n < RANDOM_KEYS; n++) begin
      case ($urandom_range(0, 7))
        0: begin
          bt = 8'($urandom_range(0, 255));
          k = {16{bt}};
        end
        1: k = 128'h1 << $urandom_range(0, 127);
        default: k = {$urandom, $urandom, $urandom, $urandom};
      endcase
      cipher_keys.push_back(k);
    end
    keys_total = cipher_keys.size();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (cipher_keys.size() > 0 || in_valid) @(posedge clk);
    while (round_keys_due.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Hard limit on run time
  initial begin
    #1000000;
    $display("Verification failed");
    $finish;
  end

endmodule
